>>> rtl/core/arp_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types and protocol constants for the ARP cache table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arp_pkg;

	// ARP header values accepted for Ethernet / IPv4
	localparam logic [15:0] ARP_HTYPE_ETH  = 16'h0001;
	localparam logic [15:0] ARP_PTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  ARP_HLEN_ETH   = 8'd6;
	localparam logic [7:0]  ARP_PLEN_IPV4  = 8'd4;

	// ARP operation codes
	localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
	localparam logic [15:0] ARP_OP_REPLY   = 16'd2;

	// Item kinds
	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_PACKET = 1'b1;

	// One table entry as stored in the memory
	typedef struct packed {
		logic [47:0] mac;
		logic [31:0] ip;
	} arp_entry_t;

	// One result word
	typedef struct packed {
		logic        hit;
		logic [47:0] found_mac;
		logic        accepted;
		logic        reply_needed;
		logic [47:0] reply_mac;
		logic [31:0] reply_ip;
	} arp_result_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} arp_state_t;

endpackage

`default_nettype wire

>>> rtl/core/arp_cache_table.sv
// Flow: a rejected packet skips the scan; a lookup or learned packet scans the
// filled entries in index order, ending early on a match.
// Handshake: one word at a time; the next word is taken only after the
// result is parked in the output register. The table memory is scanned one
// entry per cycle.
// Reset (arst_n low): table empty, replace pointer at entry 0, no result held.
// ----------------------------------------------------------------------------
// ARP cache table
// MAC/IP pair cache with in-order lookup and round-robin learning of senders.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_table
	import arp_pkg::*;
#(
	parameter int ENTRIES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input channel
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [31:0] query_ip,
	input  wire logic [15:0] hw_type,
	input  wire logic [15:0] proto_type,
	input  wire logic [7:0]  hw_len,
	input  wire logic [7:0]  proto_len,
	input  wire logic [15:0] operation,
	input  wire logic [47:0] sender_mac,
	input  wire logic [31:0] sender_ip,
	// output channel
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             hit,
	output logic [47:0]      found_mac,
	output logic             accepted,
	output logic             reply_needed,
	output logic [47:0]      reply_mac,
	output logic [31:0]      reply_ip
);

	localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNTW = $clog2(ENTRIES + 1);

	// state and control registers
	arp_state_t        state_q, state_d;
	logic [CNTW-1:0]   fill_q;
	logic [IDXW-1:0]   rptr_q;
	logic [CNTW-1:0]   rd_cnt_q;
	logic              vld_s1;
	logic [IDXW-1:0]   idx_s1;
	arp_entry_t        rd_entry_s1;
	logic              out_valid_q;

	// captured item
	logic              kind_q;
	logic              req_q;
	logic [47:0]       mac_q;
	logic [31:0]       ip_q;

	// pending result and output register
	arp_result_t       res_q;
	arp_result_t       res_d;
	arp_result_t       out_q;

	// table memory
	arp_entry_t        mem [ENTRIES];
	logic              wr_en;
	logic [IDXW-1:0]   wr_addr;
	arp_entry_t        wr_data;

	logic              in_fire;
	logic              hdr_ok;
	logic              reject;
	logic              scan_on;
	logic              done_on;
	logic              rd_issue;
	logic              match;
	logic              last;
	logic              finish;
	logic              load_out;

	// header check and handshake
	assign hdr_ok  = (hw_type == ARP_HTYPE_ETH) && (proto_type == ARP_PTYPE_IPV4) &&
	                 (hw_len == ARP_HLEN_ETH) && (proto_len == ARP_PLEN_IPV4);
	assign in_fire = in_valid && in_ready;
	assign reject  = (kind == KIND_PACKET) && !hdr_ok;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = reject ? ST_DONE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (finish) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state decode
	always_comb begin
		in_ready = 1'b0;
		scan_on  = 1'b0;
		done_on  = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SCAN: scan_on  = 1'b1;
			ST_DONE: done_on  = 1'b1;
			default: in_ready = 1'b0;
		endcase
	end

	// compare the entry read last cycle against the search key
	assign match = vld_s1 && ((kind_q == KIND_PACKET) ? (rd_entry_s1.mac == mac_q)
	                                                  : (rd_entry_s1.ip == ip_q));
	assign last  = vld_s1 && ((CNTW'(idx_s1) + CNTW'(1)) == fill_q);
	assign finish   = scan_on && (match || last || (fill_q == '0));
	assign rd_issue = scan_on && !finish && (rd_cnt_q < fill_q);
	assign load_out = done_on && (!out_valid_q || out_ready);

	// write back: overwrite the IP of a known MAC, else replace at the pointer
	always_comb begin
		wr_en       = finish && (kind_q == KIND_PACKET);
		wr_addr     = match ? idx_s1 : rptr_q;
		wr_data.mac = match ? rd_entry_s1.mac : mac_q;
		wr_data.ip  = ip_q;
	end

	// result of a finished scan
	always_comb begin
		res_d = '0;
		if (kind_q == KIND_PACKET) begin
			res_d.accepted = 1'b1;
			if (req_q) begin
				res_d.reply_needed = 1'b1;
				res_d.reply_mac    = mac_q;
				res_d.reply_ip     = ip_q;
			end
		end else if (match) begin
			res_d.hit       = 1'b1;
			res_d.found_mac = rd_entry_s1.mac;
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_entry_s1 <= mem[rd_cnt_q[IDXW-1:0]];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			rptr_q      <= '0;
			rd_cnt_q    <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_issue;
			// advance the read index while scanning, rewind on a new word
			if (in_fire) begin
				rd_cnt_q <= '0;
			end else if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + CNTW'(1);
			end
			// round-robin replacement of a new sender
			if (wr_en && !match) begin
				rptr_q <= (rptr_q == IDXW'(ENTRIES - 1)) ? '0 : rptr_q + IDXW'(1);
				if (fill_q != CNTW'(ENTRIES)) begin
					fill_q <= fill_q + CNTW'(1);
				end
			end
			// output register valid
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= rd_cnt_q[IDXW-1:0];
		if (in_fire) begin
			kind_q <= kind;
			req_q  <= (operation == ARP_OP_REQUEST);
			mac_q  <= sender_mac;
			ip_q   <= (kind == KIND_PACKET) ? sender_ip : query_ip;
			res_q  <= '0;
		end else if (finish) begin
			res_q <= res_d;
		end
		if (load_out) begin
			out_q <= res_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = out_q.hit;
	assign found_mac    = out_q.found_mac;
	assign accepted     = out_q.accepted;
	assign reply_needed = out_q.reply_needed;
	assign reply_mac    = out_q.reply_mac;
	assign reply_ip     = out_q.reply_ip;

endmodule

`default_nettype wire

>>> rtl/core/arp_checker.sv
// ----------------------------------------------------------------------------
// ARP cache checker
// Port-level assertions on the result channel of the ARP cache table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        hit,
	input wire logic [47:0] found_mac,
	input wire logic        accepted,
	input wire logic        reply_needed,
	input wire logic [47:0] reply_mac,
	input wire logic [31:0] reply_ip
);

	// a stalled result word stays valid and holds found_mac and reply_ip
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found_mac) && $stable(reply_ip))
		else $error("result word changed while stalled");

	// a word is never both a lookup hit and an accepted packet
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && accepted))
		else $error("hit and accepted both set");

	// reply only for an accepted packet, address fields clear otherwise
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reply_needed |-> reply_mac == 48'd0 && reply_ip == 32'd0)
		else $error("reply address without reply");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reply_needed |-> accepted)
		else $error("reply flagged for a packet not accepted");

	// a miss carries no MAC
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> found_mac == 48'd0)
		else $error("MAC reported on a miss");

endmodule

bind arp_cache_table arp_checker u_arp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.hit          (hit),
	.found_mac    (found_mac),
	.accepted     (accepted),
	.reply_needed (reply_needed),
	.reply_mac    (reply_mac),
	.reply_ip     (reply_ip)
);

`default_nettype wire

>>> sim/arp_cache_table_tb.sv
// ----------------------------------------------------------------------------
// ARP cache table testbench
// Drives lookup and ARP packet words through the cache with random gaps and output
// stalls, predicts each result word from a local table copy unless a directed row
// gives it, and compares each returned word field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arp_cache_table_tb;
	import arp_pkg::*;

	localparam int ENTRIES      = 8;
	localparam int RANDOM_WORDS = 530;
	localparam int HOLD_AT      = 120;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 3000;
	localparam int SETTLE       = ENTRIES + 8;

	// one input word
	typedef struct packed {
		logic        kind;
		logic [31:0] query_ip;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [7:0]  hw_len;
		logic [7:0]  proto_len;
		logic [15:0] operation;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
	} arp_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = 1'b0;
	logic [31:0] query_ip = '0;
	logic [15:0] hw_type = '0;
	logic [15:0] proto_type = '0;
	logic [7:0]  hw_len = '0;
	logic [7:0]  proto_len = '0;
	logic [15:0] operation = '0;
	logic [47:0] sender_mac = '0;
	logic [31:0] sender_ip = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        hit;
	logic [47:0] found_mac;
	logic        accepted;
	logic        reply_needed;
	logic [47:0] reply_mac;
	logic [31:0] reply_ip;

	// golden value riding along with the word on the input port
	logic        golden_on = 1'b0;
	arp_result_t golden_word = '0;

	// local copy of the cache
	logic [47:0] cache_mac [ENTRIES];
	logic [31:0] cache_ip [ENTRIES];
	int          cache_fill = 0;
	int          cache_next = 0;

	arp_result_t pending_results [$];
	arp_word_t   table_words [$];
	logic        table_golden_on [$];
	arp_result_t table_golden [$];
	logic [47:0] mac_pool [$];
	logic [31:0] ip_pool [$];

	int   fail_count = 0;
	int   items_taken = 0;
	int   results_taken = 0;
	int   quiet = 0;
	logic rx_holding = 1'b0;

	arp_cache_table #(
		.ENTRIES(ENTRIES)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.query_ip    (query_ip),
		.hw_type     (hw_type),
		.proto_type  (proto_type),
		.hw_len      (hw_len),
		.proto_len   (proto_len),
		.operation   (operation),
		.sender_mac  (sender_mac),
		.sender_ip   (sender_ip),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.found_mac   (found_mac),
		.accepted    (accepted),
		.reply_needed(reply_needed),
		.reply_mac   (reply_mac),
		.reply_ip    (reply_ip)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Predict the result word of one input word and update the cache copy
	function automatic arp_result_t resolve_word(input arp_word_t w);
		arp_result_t r;
		logic        found;
		r = '0;
		found = 1'b0;
		if (w.kind == KIND_LOOKUP) begin
			// first filled entry in index order wins
			for (int i = 0; i < cache_fill; i++) begin
				if (!found && cache_ip[i] == w.query_ip) begin
					found = 1'b1;
					r.hit = 1'b1;
					r.found_mac = cache_mac[i];
				end
			end
		end else if (w.hw_type == ARP_HTYPE_ETH && w.proto_type == ARP_PTYPE_IPV4 &&
				w.hw_len == ARP_HLEN_ETH && w.proto_len == ARP_PLEN_IPV4) begin
			r.accepted = 1'b1;
			if (w.operation == ARP_OP_REQUEST) begin
				r.reply_needed = 1'b1;
				r.reply_mac = w.sender_mac;
				r.reply_ip = w.sender_ip;
			end
			// known sender: refresh its IP in the lowest matching entry
			for (int i = 0; i < cache_fill; i++) begin
				if (!found && cache_mac[i] == w.sender_mac) begin
					found = 1'b1;
					cache_ip[i] = w.sender_ip;
				end
			end
			// new sender: replace round robin
			if (!found) begin
				cache_mac[cache_next] = w.sender_mac;
				cache_ip[cache_next] = w.sender_ip;
				cache_next = (cache_next + 1) % ENTRIES;
				if (cache_fill < ENTRIES)
					cache_fill++;
			end
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, actual %h", name, want, got);
			fail_count++;
		end
	endfunction

	// Directed table rows
	function automatic void add_lookup(input logic [31:0] ip, input logic check,
			input logic want_hit, input logic [47:0] want_mac);
		arp_word_t   w;
		arp_result_t r;
		logic [63:0] r64;
		r64 = {$urandom, $urandom};
		// packet fields carry junk that the block must ignore
		w = '{kind: KIND_LOOKUP, query_ip: ip, hw_type: 16'($urandom),
			proto_type: 16'($urandom), hw_len: 8'($urandom), proto_len: 8'($urandom),
			operation: 16'($urandom), sender_mac: r64[47:0], sender_ip: $urandom};
		r = '0;
		r.hit = want_hit;
		r.found_mac = want_mac;
		table_words.push_back(w);
		table_golden_on.push_back(check);
		table_golden.push_back(r);
	endfunction

	function automatic void add_packet(input logic [15:0] ht, input logic [15:0] pt,
			input logic [7:0] hl, input logic [7:0] pl, input logic [15:0] op,
			input logic [47:0] mac, input logic [31:0] ip, input logic check,
			input logic want_acc, input logic want_reply);
		arp_word_t   w;
		arp_result_t r;
		w = '{kind: KIND_PACKET, query_ip: $urandom, hw_type: ht, proto_type: pt,
			hw_len: hl, proto_len: pl, operation: op, sender_mac: mac, sender_ip: ip};
		r = '0;
		r.accepted = want_acc;
		r.reply_needed = want_reply;
		r.reply_mac = want_reply ? mac : '0;
		r.reply_ip = want_reply ? ip : '0;
		table_words.push_back(w);
		table_golden_on.push_back(check);
		table_golden.push_back(r);
	endfunction

	function automatic void build_directed();
		// empty table misses at both ends of the address range
		add_lookup(32'h0000_0000, 1'b1, 1'b0, '0);
		add_lookup(32'hffff_ffff, 1'b1, 1'b0, '0);
		// rejected headers: one bad field each, then all fields at maximum
		add_packet(16'h0000, ARP_PTYPE_IPV4, ARP_HLEN_ETH, ARP_PLEN_IPV4, ARP_OP_REQUEST,
			48'h0000_0000_0001, 32'h0a00_0001, 1'b1, 1'b0, 1'b0);
		add_packet(ARP_HTYPE_ETH, 16'h0806, ARP_HLEN_ETH, ARP_PLEN_IPV4, ARP_OP_REQUEST,
			48'h0000_0000_0001, 32'h0a00_0001, 1'b1, 1'b0, 1'b0);
		add_packet(ARP_HTYPE_ETH, ARP_PTYPE_IPV4, 8'd5, ARP_PLEN_IPV4, ARP_OP_REQUEST,
			48'h0000_0000_0001, 32'h0a00_0001, 1'b1, 1'b0, 1'b0);
		add_packet(ARP_HTYPE_ETH, ARP_PTYPE_IPV4, ARP_HLEN_ETH, 8'd16, ARP_OP_REQUEST,
			48'h0000_0000_0001, 32'h0a00_0001, 1'b1, 1'b0, 1'b0);
		add_packet(16'hffff, 16'hffff, 8'hff, 8'hff, 16'hffff,
			48'hffff_ffff_ffff, 32'hffff_ffff, 1'b1, 1'b0, 1'b0);
		// rejected packets leave nothing behind
		add_lookup(32'h0a00_0001, 1'b1, 1'b0, '0);
		// learn at the extremes, request and response
		add_packet(ARP_HTYPE_ETH, ARP_PTYPE_IPV4, ARP_HLEN_ETH, ARP_PLEN_IPV4,
			ARP_OP_REQUEST, 48'h0000_0000_0000, 32'h0000_0000, 1'b1, 1'b1, 1'b1);
		add_lookup(32'h0000_0000, 1'b0, 1'b0, '0);
		add_packet(ARP_HTYPE_ETH, ARP_PTYPE_IPV4, ARP_HLEN_ETH, ARP_PLEN_IPV4,
			ARP_OP_REPLY, 48'hffff_ffff_ffff, 32'hffff_ffff, 1'b1, 1'b1, 1'b0);
		// unknown operations are learned without a reply
		add_packet(ARP_HTYPE_ETH, ARP_PTYPE_IPV4, ARP_HLEN_ETH, ARP_PLEN_IPV4, 16'h0000,
			48'h0123_4567_89ab, 32'h0a00_0001, 1'b1, 1'b1, 1'b0);
		add_packet(ARP_HTYPE_ETH, ARP_PTYPE_IPV4, ARP_HLEN_ETH, ARP_PLEN_IPV4, 16'hffff,
			48'h8000_0000_0000, 32'h0a0a_0a0a, 1'b1, 1'b1, 1'b0);
		add_lookup(32'hffff_ffff, 1'b0, 1'b0, '0);
		// known MAC: overwrite its IP in place
		add_packet(ARP_HTYPE_ETH, ARP_PTYPE_IPV4, ARP_HLEN_ETH, ARP_PLEN_IPV4,
			ARP_OP_REQUEST, 48'h0000_0000_0000, 32'hc0a8_0001, 1'b1, 1'b1, 1'b1);
		add_lookup(32'h0000_0000, 1'b0, 1'b0, '0);
		add_lookup(32'hc0a8_0001, 1'b0, 1'b0, '0);
		// fill the table and wrap the replace pointer; first one shares an IP
		for (int i = 0; i < 5; i++)
			add_packet(ARP_HTYPE_ETH, ARP_PTYPE_IPV4, ARP_HLEN_ETH, ARP_PLEN_IPV4,
				ARP_OP_REPLY, 48'h0000_0000_0010 + 48'(i),
				(i == 0) ? 32'h0a0a_0a0a : 32'h0b00_0000 + 32'(i), 1'b1, 1'b1, 1'b0);
		// duplicate IP resolves to the lower entry; wrapped entry is gone
		add_lookup(32'h0a0a_0a0a, 1'b0, 1'b0, '0);
		add_lookup(32'hc0a8_0001, 1'b0, 1'b0, '0);
		add_lookup(32'h0a00_0001, 1'b0, 1'b0, '0);
	endfunction

	// Random word: mostly well-formed packets and lookups that can hit
	function automatic arp_word_t draw_word();
		arp_word_t   w;
		logic [63:0] r64;
		int          roll;
		r64 = {$urandom, $urandom};
		w = '{kind: ($urandom_range(0, 99) < 40) ? KIND_LOOKUP : KIND_PACKET,
			query_ip: $urandom, hw_type: 16'($urandom), proto_type: 16'($urandom),
			hw_len: 8'($urandom), proto_len: 8'($urandom), operation: 16'($urandom),
			sender_mac: r64[47:0], sender_ip: $urandom};
		if (w.kind == KIND_LOOKUP) begin
			if (ip_pool.size() != 0 && $urandom_range(0, 99) < 70)
				w.query_ip = ip_pool[$urandom_range(0, ip_pool.size() - 1)];
			return w;
		end
		w.hw_type = ARP_HTYPE_ETH;
		w.proto_type = ARP_PTYPE_IPV4;
		w.hw_len = ARP_HLEN_ETH;
		w.proto_len = ARP_PLEN_IPV4;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			w.operation = ARP_OP_REQUEST;
		else if (roll < 90)
			w.operation = ARP_OP_REPLY;
		// reuse senders so that refreshes happen
		if (mac_pool.size() != 0 && $urandom_range(0, 99) < 35)
			w.sender_mac = mac_pool[$urandom_range(0, mac_pool.size() - 1)];
		// narrow IP set so that several entries share an address
		if ($urandom_range(0, 99) < 15)
			w.sender_ip = 32'h0a00_0000 + $urandom_range(0, 7);
		if ($urandom_range(0, 99) < 12) begin
			// break one header field
			case ($urandom_range(0, 3))
				0: w.hw_type = 16'($urandom);
				1: w.proto_type = 16'($urandom);
				2: w.hw_len = 8'($urandom);
				default: w.proto_len = 8'($urandom);
			endcase
		end else begin
			mac_pool.push_back(w.sender_mac);
			ip_pool.push_back(w.sender_ip);
			if (mac_pool.size() > 16)
				void'(mac_pool.pop_front());
			if (ip_pool.size() > 16)
				void'(ip_pool.pop_front());
		end
		return w;
	endfunction

	function automatic int pick_gap(input int n);
		if (rx_holding || (n / 40) % 5 == 4)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	// Offer one word; returns at the edge that takes it
	task automatic offer_word(input arp_word_t w, input logic check, input arp_result_t gold,
			input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= w.kind;
		query_ip <= w.query_ip;
		hw_type <= w.hw_type;
		proto_type <= w.proto_type;
		hw_len <= w.hw_len;
		proto_len <= w.proto_len;
		operation <= w.operation;
		sender_mac <= w.sender_mac;
		sender_ip <= w.sender_ip;
		golden_on <= check;
		golden_word <= gold;
		@(posedge clk);
		while (!(in_valid && in_ready))
			@(posedge clk);
	endtask

	// Hold the input until every result word is back
	task automatic drain_all();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_taken != items_taken)
			@(posedge clk);
	endtask

	// Stimulus
	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		build_directed();
		foreach (table_words[i])
			offer_word(table_words[i], table_golden_on[i], table_golden[i], pick_gap(i));
		drain_all();
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS / 2)
				drain_all();
			offer_word(draw_word(), 1'b0, '0, pick_gap(n));
		end
		drain_all();
		repeat (SETTLE) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("results: expected %0d more words, actual 0", pending_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("arp_cache_table regression: pass");
		else
			$display("arp_cache_table regression: fail");
		$finish;
	end

	// Result side: random stalls, one long hold-off to back up the input
	initial begin : receiver
		int taken;
		int stall;
		taken = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (taken == HOLD_AT) begin
				stall = HOLD_CYCLES;
				rx_holding <= 1'b1;
			end else if ((taken / 35) % 5 == 2) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 17);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rx_holding <= 1'b0;
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready))
				@(posedge clk);
			taken++;
		end
	end

	// Check returned words, then predict newly taken ones
	always @(posedge clk) begin : scoreboard
		arp_word_t   w;
		arp_result_t want;
		arp_result_t pred;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("out word: expected none, actual hit=%0d acc=%0d", hit, accepted);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("hit", 64'(want.hit), 64'(hit));
				check_field("found_mac", 64'(want.found_mac), 64'(found_mac));
				check_field("accepted", 64'(want.accepted), 64'(accepted));
				check_field("reply_needed", 64'(want.reply_needed), 64'(reply_needed));
				check_field("reply_mac", 64'(want.reply_mac), 64'(reply_mac));
				check_field("reply_ip", 64'(want.reply_ip), 64'(reply_ip));
			end
			results_taken <= results_taken + 1;
		end
		if (in_valid && in_ready) begin
			w = '{kind: kind, query_ip: query_ip, hw_type: hw_type, proto_type: proto_type,
				hw_len: hw_len, proto_len: proto_len, operation: operation,
				sender_mac: sender_mac, sender_ip: sender_ip};
			pred = resolve_word(w);
			pending_results.push_back(golden_on ? golden_word : pred);
			items_taken <= items_taken + 1;
		end
	end

	// Watchdog: end the run when no word moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("arp_cache_table regression: fail");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

endmodule

>>> filelist.f
rtl/core/arp_pkg.sv
rtl/core/arp_cache_table.sv
rtl/core/arp_checker.sv
sim/arp_cache_table_tb.sv
